// ----- design/intel_hex_record_parser_assert.svh -----
// assertion macros for the parser's top-level rtl
`ifndef INTEL_HEX_RECORD_PARSER_ASSERT_SVH
`define INTEL_HEX_RECORD_PARSER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IHEX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ihex assertion failed");

// next-cycle implication, checked outside reset
`define IHEX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ihex assertion failed");

`endif

// ----- design/ihex_pkg.sv -----
// types and constants of the intel hex record parser
package ihex_pkg;

  localparam int unsigned POS_W = 10;

  localparam logic [POS_W-1:0] POS_MAX      = 10'd1023;
  localparam logic [POS_W-1:0] POS_LEN_END  = 10'd2;
  localparam logic [POS_W-1:0] POS_OFS_END  = 10'd6;
  localparam logic [POS_W-1:0] POS_TYPE_HI  = 10'd7;
  localparam logic [POS_W-1:0] POS_TYPE_LO  = 10'd8;
  localparam logic [POS_W-1:0] POS_MIN_LINE = 10'd9;
  localparam logic [POS_W-1:0] POS_EXT_END  = 10'd12;
  localparam logic [POS_W-1:0] POS_EXT_LINE = 10'd13;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_EOF   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_DELIM  = 3'd0;
  localparam logic [2:0] ERR_TYPE   = 3'd1;
  localparam logic [2:0] ERR_EXTOFS = 3'd2;
  localparam logic [2:0] ERR_DIGIT  = 3'd3;
  localparam logic [2:0] ERR_SHORT  = 3'd4;

  localparam logic RK_DATA = 1'b0;
  localparam logic RK_EXT  = 1'b1;

  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_SEMI    = 8'h3B;
  localparam logic [7:0] CHAR_0       = 8'h30;
  localparam logic [7:0] CHAR_1       = 8'h31;
  localparam logic [7:0] CHAR_4       = 8'h34;
  localparam logic [7:0] CHAR_9       = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;

  localparam logic [31:0] UPPER_MASK = 32'hFFFF_0000;

  typedef struct packed {
    logic [7:0] text_char;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [31:0] byte_address;
    logic        chunk_start;
    logic [2:0]  error_code;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

endpackage

// ----- design/ihex_char_decode.sv -----
// ascii hex digit decoder
module ihex_char_decode (
  input  logic [7:0]          text_char,
  output ihex_pkg::hex_digit_t digit
);

  logic [7:0] from_0;
  logic [7:0] from_upper;
  logic [7:0] from_lower;

  assign from_0     = text_char - ihex_pkg::CHAR_0;
  assign from_upper = text_char - ihex_pkg::CHAR_UPPER_A + 8'd10;
  assign from_lower = text_char - ihex_pkg::CHAR_LOWER_A + 8'd10;

  always_comb begin
    digit = '0;
    if (text_char inside {[ihex_pkg::CHAR_0:ihex_pkg::CHAR_9]}) begin
      digit.ok    = 1'b1;
      digit.value = from_0[3:0];
    end else if (text_char inside {[ihex_pkg::CHAR_UPPER_A:ihex_pkg::CHAR_UPPER_F]}) begin
      digit.ok    = 1'b1;
      digit.value = from_upper[3:0];
    end else if (text_char inside {[ihex_pkg::CHAR_LOWER_A:ihex_pkg::CHAR_LOWER_F]}) begin
      digit.ok    = 1'b1;
      digit.value = from_lower[3:0];
    end
  end

endmodule

// ----- design/ihex_parse_core.sv -----
// per-character record parsing state and result decision
module ihex_parse_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  ihex_pkg::in_item_t item,
  output ihex_pkg::result_t  res
);

  ihex_pkg::hex_digit_t dig;

  logic [ihex_pkg::POS_W-1:0] char_position, char_position_next;
  logic [7:0]  record_length, record_length_next;
  logic [15:0] record_offset, record_offset_next;
  logic        record_kind, record_kind_next;
  logic [15:0] upper_address, upper_address_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [15:0] field_accumulator, field_accumulator_next;
  logic [7:0]  byte_index, byte_index_next;
  logic        skipping_line, skipping_line_next;
  logic        stopped, stopped_next;
  logic [31:0] next_address, next_address_next;
  logic        next_address_valid, next_address_valid_next;

  // state as seen after an optional restart
  logic [ihex_pkg::POS_W-1:0] pos_e;
  logic [15:0] upper_e;
  logic [7:0]  bidx_e;
  logic        skip_e;
  logic        stopped_e;
  logic        nav_e;
  logic [31:0] na_e;

  logic [15:0] acc_shift;
  logic [31:0] addr;
  logic        is_eol;
  logic        line_short;
  logic        do_emit;
  logic [1:0]  emit_kind;
  logic [2:0]  emit_code;

  ihex_char_decode u_dec (
    .text_char (item.text_char),
    .digit     (dig)
  );

  assign pos_e     = item.restart ? '0 : char_position;
  assign upper_e   = item.restart ? '0 : upper_address;
  assign bidx_e    = item.restart ? '0 : byte_index;
  assign skip_e    = item.restart ? 1'b0 : skipping_line;
  assign stopped_e = item.restart ? 1'b0 : stopped;
  assign nav_e     = item.restart ? 1'b0 : next_address_valid;
  assign na_e      = item.restart ? '0 : next_address;

  assign acc_shift = {field_accumulator[11:0], dig.value};
  assign addr = (({upper_e, 16'h0000}) & ihex_pkg::UPPER_MASK)
              + {16'h0000, record_offset} + {24'h000000, bidx_e};
  assign is_eol = (item.text_char == ihex_pkg::CHAR_CR) ||
                  (item.text_char == ihex_pkg::CHAR_LF);
  assign line_short = (pos_e < ihex_pkg::POS_MIN_LINE) ||
                      (record_kind == ihex_pkg::RK_DATA && bidx_e < record_length) ||
                      (record_kind == ihex_pkg::RK_EXT && pos_e < ihex_pkg::POS_EXT_LINE);

  always_comb begin
    char_position_next      = char_position;
    record_length_next      = record_length;
    record_offset_next      = record_offset;
    record_kind_next        = record_kind;
    upper_address_next      = upper_address;
    high_nibble_next        = high_nibble;
    field_accumulator_next  = field_accumulator;
    byte_index_next         = byte_index;
    skipping_line_next      = skipping_line;
    stopped_next            = stopped;
    next_address_next       = next_address;
    next_address_valid_next = next_address_valid;
    res       = '0;
    do_emit   = 1'b0;
    emit_kind = ihex_pkg::KIND_ERROR;
    emit_code = ihex_pkg::ERR_DELIM;

    if (accept) begin
      char_position_next      = pos_e;
      upper_address_next      = upper_e;
      byte_index_next         = bidx_e;
      skipping_line_next      = skip_e;
      stopped_next            = stopped_e;
      next_address_next       = na_e;
      next_address_valid_next = nav_e;

      if (!stopped_e) begin
        if (is_eol) begin
          if (!skip_e && pos_e != '0 && line_short) begin
            do_emit   = 1'b1;
            emit_code = ihex_pkg::ERR_SHORT;
          end else begin
            char_position_next = '0;
            byte_index_next    = '0;
            skipping_line_next = 1'b0;
          end
        end else if (!skip_e) begin
          char_position_next = (pos_e < ihex_pkg::POS_MAX) ?
                               pos_e + 10'd1 : pos_e;
          if (pos_e == '0) begin
            if (item.text_char == ihex_pkg::CHAR_SEMI) begin
              skipping_line_next = 1'b1;
            end else if (item.text_char != ihex_pkg::CHAR_COLON) begin
              do_emit   = 1'b1;
              emit_code = ihex_pkg::ERR_DELIM;
            end
          end else if (pos_e <= ihex_pkg::POS_OFS_END) begin
            if (!dig.ok) begin
              do_emit   = 1'b1;
              emit_code = ihex_pkg::ERR_DIGIT;
            end else begin
              field_accumulator_next = acc_shift;
              if (pos_e == ihex_pkg::POS_LEN_END) record_length_next = acc_shift[7:0];
              if (pos_e == ihex_pkg::POS_OFS_END) record_offset_next = acc_shift;
            end
          end else if (pos_e == ihex_pkg::POS_TYPE_HI) begin
            // high type digit is not looked at
          end else if (pos_e == ihex_pkg::POS_TYPE_LO) begin
            byte_index_next        = '0;
            field_accumulator_next = '0;
            case (item.text_char)
              ihex_pkg::CHAR_1: begin
                do_emit   = 1'b1;
                emit_kind = ihex_pkg::KIND_EOF;
                emit_code = ihex_pkg::ERR_DELIM;
              end
              ihex_pkg::CHAR_0: begin
                record_kind_next = ihex_pkg::RK_DATA;
              end
              ihex_pkg::CHAR_4: begin
                record_kind_next = ihex_pkg::RK_EXT;
                if (record_offset != 16'h0000) begin
                  do_emit   = 1'b1;
                  emit_code = ihex_pkg::ERR_EXTOFS;
                end
              end
              default: begin
                do_emit   = 1'b1;
                emit_code = ihex_pkg::ERR_TYPE;
              end
            endcase
          end else if (record_kind == ihex_pkg::RK_EXT) begin
            if (pos_e <= ihex_pkg::POS_EXT_END) begin
              if (!dig.ok) begin
                do_emit   = 1'b1;
                emit_code = ihex_pkg::ERR_DIGIT;
              end else begin
                field_accumulator_next = acc_shift;
                if (pos_e == ihex_pkg::POS_EXT_END) upper_address_next = acc_shift;
              end
            end
          end else if (bidx_e < record_length) begin
            if (!dig.ok) begin
              do_emit   = 1'b1;
              emit_code = ihex_pkg::ERR_DIGIT;
            end else if (pos_e[0]) begin
              // odd position: first digit of a payload byte
              high_nibble_next = dig.value;
            end else begin
              res.valid                = 1'b1;
              res.item.kind            = ihex_pkg::KIND_DATA;
              res.item.data_byte       = {high_nibble, dig.value};
              res.item.byte_address    = addr;
              res.item.chunk_start     = !nav_e || (addr != na_e);
              next_address_next        = addr + 32'd1;
              next_address_valid_next  = 1'b1;
              byte_index_next          = bidx_e + 8'd1;
            end
          end
        end
      end

      if (do_emit) begin
        res.valid           = 1'b1;
        res.item.kind       = emit_kind;
        res.item.error_code = (emit_kind == ihex_pkg::KIND_ERROR) ?
                              emit_code : ihex_pkg::ERR_DELIM;
        stopped_next        = 1'b1;
        char_position_next  = '0;
        byte_index_next     = '0;
        skipping_line_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position      <= '0;
      record_length      <= '0;
      record_offset      <= '0;
      record_kind        <= ihex_pkg::RK_DATA;
      upper_address      <= '0;
      high_nibble        <= '0;
      field_accumulator  <= '0;
      byte_index         <= '0;
      skipping_line      <= 1'b0;
      stopped            <= 1'b0;
      next_address       <= '0;
      next_address_valid <= 1'b0;
    end else begin
      char_position      <= char_position_next;
      record_length      <= record_length_next;
      record_offset      <= record_offset_next;
      record_kind        <= record_kind_next;
      upper_address      <= upper_address_next;
      high_nibble        <= high_nibble_next;
      field_accumulator  <= field_accumulator_next;
      byte_index         <= byte_index_next;
      skipping_line      <= skipping_line_next;
      stopped            <= stopped_next;
      next_address       <= next_address_next;
      next_address_valid <= next_address_valid_next;
    end
  end

endmodule

// ----- design/ihex_out_skid.sv -----
// output register with one skid entry
module ihex_out_skid (
  input  logic                clk,
  input  logic                rst,
  input  ihex_pkg::result_t   res,
  input  logic                rec_stall,
  output logic                rec_valid,
  output ihex_pkg::out_item_t rec_item,
  output logic                skid_full
);

  ihex_pkg::out_item_t skid_item;
  logic                slot_free;

  assign slot_free = !rec_valid || !rec_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (slot_free) begin
      if (skid_full) begin
        rec_valid <= 1'b1;
        skid_full <= res.valid;
      end else begin
        rec_valid <= res.valid;
      end
    end else if (res.valid) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (skid_full) begin
        rec_item <= skid_item;
        if (res.valid) skid_item <= res.item;
      end else if (res.valid) begin
        rec_item <= res.item;
      end
    end else if (res.valid) begin
      skid_item <= res.item;
    end
  end

endmodule

// ----- design/intel_hex_record_parser.sv -----
// intel hex record parser: streaming character input, data byte / status output
//
// char channel: one ascii character per transfer (char_item.text_char) plus
// restart, which clears the stop condition, upper address, line state and
// chunk tracking before that character is parsed.
// rec channel: zero or one result per character: a data byte with its 32-bit
// address and chunk start flag, an end-of-file mark, or an error code.
// after end of file or an error no further results appear until restart.
// a result is registered in the output register, or in the skid entry under stall.
// throughput: one character per cycle unless char_stall; the parse state updates
// in a single pass of logic between the state registers and the output register.
// stall: the output register plus one skid entry hold results; char_stall
// rises while the skid entry is occupied, so up to two results can wait.
// reset (rst, synchronous): clears parse state and empties the output side.
module intel_hex_record_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_stall,
  input  ihex_pkg::in_item_t  char_item,
  output logic                rec_valid,
  input  logic                rec_stall,
  output ihex_pkg::out_item_t rec_item
);

  `include "intel_hex_record_parser_assert.svh"

  ihex_pkg::result_t res;
  logic              accept;
  logic              skid_full;

  assign char_stall = skid_full;
  assign accept     = char_valid && !char_stall;

  ihex_parse_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (char_item),
    .res    (res)
  );

  ihex_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .rec_stall (rec_stall),
    .rec_valid (rec_valid),
    .rec_item  (rec_item),
    .skid_full (skid_full)
  );

  `IHEX_ASSERT_NOW(a_skid_behind_out, skid_full, rec_valid)
  `IHEX_ASSERT_NOW(a_no_result_when_full, res.valid, !skid_full)
  `IHEX_ASSERT_NOW(a_status_fields_clear,
    rec_valid && rec_item.kind != ihex_pkg::KIND_DATA,
    rec_item.byte_address == 32'h0 && rec_item.data_byte == 8'h00 && !rec_item.chunk_start)
  `IHEX_ASSERT_NOW(a_result_needs_accept, !accept, !res.valid)
  `IHEX_ASSERT_NEXT(a_stalled_result_holds, rec_valid && rec_stall,
    rec_valid && $stable(rec_item))

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for the intel hex record parser
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] NO_ERROR = '0;
  localparam int LONG_LINE = 6;

  typedef struct {
    bit                  restart;
    string               text;
    bit                  pin;
    ihex_pkg::out_item_t want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                char_valid = 1'b0;
  logic                char_stall;
  ihex_pkg::in_item_t  char_item = '0;
  logic                rec_valid;
  logic                rec_stall = 1'b0;
  ihex_pkg::out_item_t rec_item;

  // parser state as the checker sees it
  logic [9:0]  pos_q = '0;
  logic [7:0]  rec_len = '0;
  logic [15:0] rec_ofs = '0;
  logic        rec_kind = ihex_pkg::RK_DATA;
  logic [15:0] upper_addr = '0;
  logic [3:0]  hi_nib = '0;
  logic [15:0] acc = '0;
  logic [7:0]  byte_idx = '0;
  logic        skip_line = 1'b0;
  logic        halted = 1'b0;
  logic [31:0] next_addr = '0;
  logic        next_addr_ok = 1'b0;

  ihex_pkg::out_item_t pending_recs[$];
  logic [7:0]          line_buf[$];
  int                  sent_count = 0;
  int                  fail_count = 0;

  // "\015" is cr, "\n" is lf, "\377" is the top character code
  dir_row_t dir_rows[10] = '{
    '{1'b0, "x", 1'b1,
      ihex_pkg::out_item_t'{ihex_pkg::KIND_ERROR, 8'h00, 32'h0, 1'b0, ihex_pkg::ERR_DELIM}},
    '{1'b0, ":0", 1'b0, '0},
    '{1'b1, ";\377\015\n", 1'b0, '0},
    '{1'b0, ":02000004FFFF\n", 1'b0, '0},
    '{1'b0, ":02FFFF\3770fF01\n", 1'b0, '0},
    '{1'b0, ":00000001FF", 1'b1,
      ihex_pkg::out_item_t'{ihex_pkg::KIND_EOF, 8'h00, 32'h0, 1'b0, NO_ERROR}},
    '{1'b1, ":0G", 1'b1,
      ihex_pkg::out_item_t'{ihex_pkg::KIND_ERROR, 8'h00, 32'h0, 1'b0, ihex_pkg::ERR_DIGIT}},
    '{1'b1, ":01\015", 1'b1,
      ihex_pkg::out_item_t'{ihex_pkg::KIND_ERROR, 8'h00, 32'h0, 1'b0, ihex_pkg::ERR_SHORT}},
    '{1'b1, ":00000002", 1'b1,
      ihex_pkg::out_item_t'{ihex_pkg::KIND_ERROR, 8'h00, 32'h0, 1'b0, ihex_pkg::ERR_TYPE}},
    '{1'b1, ":02000104", 1'b1,
      ihex_pkg::out_item_t'{ihex_pkg::KIND_ERROR, 8'h00, 32'h0, 1'b0, ihex_pkg::ERR_EXTOFS}}
  };

  intel_hex_record_parser u_top (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item),
    .rec_valid  (rec_valid),
    .rec_stall  (rec_stall),
    .rec_item   (rec_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic ihex_pkg::hex_digit_t hex_digit(input logic [7:0] c);
    ihex_pkg::hex_digit_t d;
    d.ok = 1'b1;
    if (c >= ihex_pkg::CHAR_0 && c <= ihex_pkg::CHAR_9)
      d.value = 4'(c - ihex_pkg::CHAR_0);
    else if (c >= ihex_pkg::CHAR_UPPER_A && c <= ihex_pkg::CHAR_UPPER_F)
      d.value = 4'(c - ihex_pkg::CHAR_UPPER_A + 8'd10);
    else if (c >= ihex_pkg::CHAR_LOWER_A && c <= ihex_pkg::CHAR_LOWER_F)
      d.value = 4'(c - ihex_pkg::CHAR_LOWER_A + 8'd10);
    else begin
      d.ok = 1'b0;
      d.value = '0;
    end
    return d;
  endfunction

  function automatic void end_line();
    pos_q = '0;
    byte_idx = '0;
    skip_line = 1'b0;
  endfunction

  function automatic bit halt_with(output ihex_pkg::out_item_t res, input logic [1:0] kind,
                                   input logic [2:0] code);
    res = '0;
    res.kind = kind;
    res.error_code = code;
    halted = 1'b1;
    end_line();
    return 1'b1;
  endfunction

  // advances the parser state by one character, returns 1 when a record comes out
  function automatic bit parse_char(input ihex_pkg::in_item_t it,
                                    output ihex_pkg::out_item_t res);
    logic [7:0]           c;
    logic [9:0]           p;
    ihex_pkg::hex_digit_t d;
    logic [31:0]          addr;
    c = it.text_char;
    res = '0;
    if (it.restart) begin
      halted = 1'b0;
      upper_addr = '0;
      next_addr_ok = 1'b0;
      next_addr = '0;
      end_line();
    end
    if (halted) return 1'b0;
    if (c == ihex_pkg::CHAR_CR || c == ihex_pkg::CHAR_LF) begin
      if (skip_line || pos_q == 0) begin
        end_line();
        return 1'b0;
      end
      if (pos_q < ihex_pkg::POS_MIN_LINE ||
          (rec_kind == ihex_pkg::RK_DATA && byte_idx < rec_len) ||
          (rec_kind == ihex_pkg::RK_EXT && pos_q < ihex_pkg::POS_EXT_LINE))
        return halt_with(res, ihex_pkg::KIND_ERROR, ihex_pkg::ERR_SHORT);
      end_line();
      return 1'b0;
    end
    if (skip_line) return 1'b0;
    p = pos_q;
    if (pos_q < ihex_pkg::POS_MAX) pos_q = pos_q + 1'b1;
    if (p == 0) begin
      if (c == ihex_pkg::CHAR_SEMI) begin
        skip_line = 1'b1;
        return 1'b0;
      end
      if (c == ihex_pkg::CHAR_COLON) return 1'b0;
      return halt_with(res, ihex_pkg::KIND_ERROR, ihex_pkg::ERR_DELIM);
    end
    d = hex_digit(c);
    if (p <= ihex_pkg::POS_OFS_END) begin
      if (!d.ok) return halt_with(res, ihex_pkg::KIND_ERROR, ihex_pkg::ERR_DIGIT);
      acc = {acc[11:0], d.value};
      if (p == ihex_pkg::POS_LEN_END) rec_len = acc[7:0];
      if (p == ihex_pkg::POS_OFS_END) rec_ofs = acc;
      return 1'b0;
    end
    if (p == ihex_pkg::POS_TYPE_HI) return 1'b0;
    if (p == ihex_pkg::POS_TYPE_LO) begin
      byte_idx = '0;
      acc = '0;
      if (c == ihex_pkg::CHAR_1) return halt_with(res, ihex_pkg::KIND_EOF, NO_ERROR);
      if (c == ihex_pkg::CHAR_0) begin
        rec_kind = ihex_pkg::RK_DATA;
        return 1'b0;
      end
      if (c == ihex_pkg::CHAR_4) begin
        rec_kind = ihex_pkg::RK_EXT;
        if (rec_ofs != 0) return halt_with(res, ihex_pkg::KIND_ERROR, ihex_pkg::ERR_EXTOFS);
        return 1'b0;
      end
      return halt_with(res, ihex_pkg::KIND_ERROR, ihex_pkg::ERR_TYPE);
    end
    if (rec_kind == ihex_pkg::RK_EXT) begin
      if (p > ihex_pkg::POS_EXT_END) return 1'b0;
      if (!d.ok) return halt_with(res, ihex_pkg::KIND_ERROR, ihex_pkg::ERR_DIGIT);
      acc = {acc[11:0], d.value};
      if (p == ihex_pkg::POS_EXT_END) upper_addr = acc;
      return 1'b0;
    end
    // checksum and anything after the payload
    if (byte_idx >= rec_len) return 1'b0;
    if (!d.ok) return halt_with(res, ihex_pkg::KIND_ERROR, ihex_pkg::ERR_DIGIT);
    if (p[0]) begin
      hi_nib = d.value;
      return 1'b0;
    end
    addr = {upper_addr, 16'h0000} + {16'h0000, rec_ofs} + {24'h000000, byte_idx};
    res.kind = ihex_pkg::KIND_DATA;
    res.data_byte = {hi_nib, d.value};
    res.byte_address = addr;
    res.chunk_start = !next_addr_ok || addr != next_addr;
    res.error_code = NO_ERROR;
    next_addr = addr + 32'd1;
    next_addr_ok = 1'b1;
    byte_idx = byte_idx + 8'd1;
    return 1'b1;
  endfunction

  function automatic logic [7:0] hex_ascii(input logic [3:0] v);
    if (v < 4'd10) return ihex_pkg::CHAR_0 + 8'(v);
    if ($urandom_range(0, 1) == 1) return ihex_pkg::CHAR_UPPER_A + 8'(v - 4'd10);
    return ihex_pkg::CHAR_LOWER_A + 8'(v - 4'd10);
  endfunction

  function automatic void add_char(input logic [7:0] c);
    line_buf.insert(line_buf.size(), c);
  endfunction

  function automatic void put_hex(input logic [31:0] v, input int ndig);
    for (int i = ndig - 1; i >= 0; i--) add_char(hex_ascii(v[4*i +: 4]));
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == ihex_pkg::CHAR_CR || c == ihex_pkg::CHAR_LF);
    return c;
  endfunction

  // one random line: mostly well-formed records, some comments, blanks and damage
  function automatic void build_line(input bit long_tail);
    int          sel;
    int          n;
    int          len;
    logic [15:0] ofs;
    logic [15:0] upper;
    line_buf.delete();
    sel = long_tail ? 0 : $urandom_range(0, 99);
    if (sel < 55 || sel >= 79) begin
      n = $urandom_range(0, 99);
      len = (n == 0) ? 255 : (n < 8) ? $urandom_range(17, 64) : $urandom_range(0, 16);
      n = $urandom_range(0, 99);
      ofs = (n < 60) ? next_addr[15:0] : (n < 70) ? 16'h0000 :
            (n < 80) ? 16'hFFFF : 16'($urandom);
      add_char(ihex_pkg::CHAR_COLON);
      put_hex(len, 2);
      put_hex(ofs, 4);
      add_char(($urandom_range(0, 9) == 0) ? text_byte() : hex_ascii(4'($urandom)));
      add_char(ihex_pkg::CHAR_0);
      repeat (len) put_hex($urandom, 2);
      put_hex($urandom, 2);
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 5)) add_char(text_byte());
    end else if (sel < 67) begin
      n = $urandom_range(0, 99);
      upper = (n < 30) ? 16'h0000 : (n < 50) ? 16'hFFFF : 16'($urandom);
      add_char(ihex_pkg::CHAR_COLON);
      put_hex(2, 2);
      put_hex(0, 4);
      add_char(ihex_pkg::CHAR_0);
      add_char(ihex_pkg::CHAR_4);
      put_hex(upper, 4);
      put_hex($urandom, 2);
    end else if (sel < 72) begin
      add_char(ihex_pkg::CHAR_SEMI);
      repeat ($urandom_range(0, 10)) add_char(text_byte());
    end else if (sel >= 76) begin
      add_char(ihex_pkg::CHAR_COLON);
      put_hex(0, 2);
      put_hex(($urandom_range(0, 1) == 1) ? 16'h0000 : 16'($urandom), 4);
      add_char(ihex_pkg::CHAR_0);
      add_char(ihex_pkg::CHAR_1);
      put_hex($urandom, 2);
    end
    if (sel >= 79) begin
      case ($urandom_range(0, 3))
        0: line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
        1: begin
          n = $urandom_range(1, line_buf.size() - 1);
          while (line_buf.size() > n) void'(line_buf.pop_back());
        end
        2: line_buf[8] = hex_ascii(4'($urandom));
        default: line_buf[8] = ihex_pkg::CHAR_4;
      endcase
    end
    // runs the position counter into saturation
    if (long_tail) while (line_buf.size() < 1040) add_char(text_byte());
    case ($urandom_range(0, 2))
      0: add_char(ihex_pkg::CHAR_CR);
      1: add_char(ihex_pkg::CHAR_LF);
      default: begin
        add_char(ihex_pkg::CHAR_CR);
        add_char(ihex_pkg::CHAR_LF);
      end
    endcase
  endfunction

  task automatic send_char(input ihex_pkg::in_item_t it, input bit pin,
                           input ihex_pkg::out_item_t want);
    ihex_pkg::out_item_t res;
    bit                  gaps_on;
    gaps_on = !(sent_count >= 100 && sent_count < 300);
    while (gaps_on && $urandom_range(0, 99) < 30) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_item <= it;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    if (parse_char(it, res)) pending_recs.insert(pending_recs.size(), pin ? want : res);
    sent_count++;
  endtask

  task automatic check_record(input ihex_pkg::out_item_t got);
    ihex_pkg::out_item_t want;
    if (pending_recs.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected record: kind %0d byte %h addr %h start %0d code %0d",
                 got.kind, got.data_byte, got.byte_address, got.chunk_start, got.error_code);
    end else begin
      want = pending_recs.pop_front();
      if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
          got.byte_address !== want.byte_address || got.chunk_start !== want.chunk_start ||
          got.error_code !== want.error_code) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("record mismatch: expected kind %0d byte %h addr %h start %0d code %0d",
                   want.kind, want.data_byte, want.byte_address, want.chunk_start,
                   want.error_code);
          $display("  got kind %0d byte %h addr %h start %0d code %0d",
                   got.kind, got.data_byte, got.byte_address, got.chunk_start,
                   got.error_code);
        end
      end
    end
  endtask

  // output side: random stalls, one long hold-off, one stretch without stalls
  initial begin : rec_side
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (rec_valid && !rec_stall) check_record(rec_item);
        cyc++;
        if (cyc >= 150 && cyc < 230) rec_stall <= 1'b1;
        else if (cyc >= 250 && cyc < 450) rec_stall <= 1'b0;
        else rec_stall <= ($urandom_range(0, 99) < 30);
      end
    end
  end

  initial begin : stimulus
    ihex_pkg::in_item_t it;
    int                 line_no;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].text.len(); k++) begin
        it.text_char = dir_rows[r].text[k];
        it.restart = dir_rows[r].restart && k == 0;
        send_char(it, dir_rows[r].pin, dir_rows[r].want);
      end
    end
    line_no = 0;
    while (sent_count < 1050) begin
      build_line(line_no == LONG_LINE);
      foreach (line_buf[i]) begin
        it.text_char = line_buf[i];
        // a stopped parser needs a restart, usually on the first character of the line
        it.restart = (i == 0 && halted && (line_no == LONG_LINE || $urandom_range(0, 99) < 85)) ||
                     $urandom_range(0, 99) == 0;
        send_char(it, 1'b0, '0);
      end
      line_no++;
    end
    char_valid <= 1'b0;
    while (pending_recs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_recs.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/ihex_pkg.sv
design/ihex_char_decode.sv
design/ihex_parse_core.sv
design/ihex_out_skid.sv
design/intel_hex_record_parser.sv
dv/testbench.sv
